>>> hw/rtl/swm_pkg.sv
// package with shared widths and constants of the moving average block
`timescale 1ns / 1ps
package swm_pkg;
    localparam int WINDOW_MAX_DEF    = 1024;
    localparam int SAMPLE_WIDTH_DEF  = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int SUM_W             = 42;
    localparam int MEAN_W            = 26;
    localparam int HELD_W            = 11;
    localparam int SCALE             = 1000;
    localparam int SCALE_W           = 10;
endpackage

>>> hw/rtl/swm_if.sv
// valid/ready channel interfaces for samples and results
`timescale 1ns / 1ps
interface swm_in_if #(parameter int SAMPLE_WIDTH = 32);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
    logic                           restart;
    modport source (output valid, sample_value, restart, input ready);
    modport sink (input valid, sample_value, restart, output ready);
endinterface

interface swm_out_if;
    logic               valid;
    logic               ready;
    logic signed [25:0] mean_thousandths;
    logic [10:0]        samples_held;
    modport source (output valid, mean_thousandths, samples_held, input ready);
    modport sink (input valid, mean_thousandths, samples_held, output ready);
endinterface

>>> hw/rtl/swm_ring.sv
// sample ring memory, one write and one registered read port
`timescale 1ns / 1ps
module swm_ring #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

>>> hw/rtl/swm_div.sv
// restoring divider for magnitude of scaled sum over held count, sign applied at end
`timescale 1ns / 1ps
module swm_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 11
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [NUM_W-1:0]         num,
    input  logic [DEN_W-1:0]         den,
    input  logic                     neg,
    output logic                     done,
    output logic signed [swm_pkg::MEAN_W-1:0] quot
);
    import swm_pkg::*;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        diff      = trial - {1'b0, d_reg};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = diff;
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done     <= busy_reg && !busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg   <= den;
            neg_reg <= neg;
        end
    end

    assign quot = neg_reg ? MEAN_W'(-q_reg[MEAN_W-1:0]) : q_reg[MEAN_W-1:0];
endmodule

>>> hw/rtl/sliding_window_mean.sv
// moving average top level: ring memory, running sum, divider and result register
// each request goes through the ring read, sum update, bit-serial divider and result register
// no new request is taken until the last result is taken; the divider gives 51 quotient bits
// the oldest sample is read from the ring on acceptance, ahead of the sum update
// reset clears sum, fill count, write position and window register (to 1)
// ring memory contents are not cleared; an evicted entry is subtracted even if never written
`timescale 1ns / 1ps
module sliding_window_mean #(
    parameter int WINDOW_MAX    = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH  = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = swm_pkg::FRACTION_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    swm_in_if.sink      in_ch,
    swm_out_if.source   out_ch
);
    import swm_pkg::*;

    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int NUM_W = SUM_W - 1 + SCALE_W;
    localparam int DEN_W = HELD_W + FRACTION_BITS;

    // state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [HELD_W-1:0]       win_reg;
    logic [HELD_W-1:0]       fill_reg, fill_next;
    logic [AW-1:0]           wpos_reg, wpos_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SAMPLE_WIDTH-1:0] samp_reg;
    logic                    evict_reg;
    logic [HELD_W-1:0]       eff_win;
    logic [SAMPLE_WIDTH-1:0] old_data;
    logic [AW-1:0]           pos_use;
    logic [HELD_W-1:0]       fill_use;
    logic [HELD_W-1:0]       held_reg;
    logic                    div_start_reg, div_done;
    logic [NUM_W-1:0]        mag_scaled;
    logic [SUM_W-1:0]        mag;
    logic signed [MEAN_W-1:0] quot;
    logic signed [MEAN_W-1:0] mean_reg;
    logic                    ovalid_reg;

    // clamp window register to 1..WINDOW_MAX
    always_comb
    begin
        if (win_reg == '0)
            eff_win = HELD_W'(1);
        else if (win_reg > HELD_W'(WINDOW_MAX))
            eff_win = HELD_W'(WINDOW_MAX);
        else
            eff_win = win_reg;
    end

    // restart and wrap applied on acceptance
    always_comb
    begin
        fill_use = in_ch.restart ? '0 : fill_reg;
        pos_use  = in_ch.restart ? '0 : wpos_reg;
        if ({{(HELD_W > AW ? HELD_W - AW : 0){1'b0}}, pos_use} >= eff_win)
            pos_use = '0;
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    wire accept = in_ch.valid && in_ch.ready;

    swm_ring #(.DEPTH(WINDOW_MAX), .WIDTH(SAMPLE_WIDTH)) u_ring (
        .clk     (clk),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (wpos_reg),
        .wr_data (samp_reg),
        .rd_en   (accept),
        .rd_addr (pos_use),
        .rd_data (old_data)
    );

    // sum update and pointer advance in the read state
    // a full window pins the fill count to the window, also after a shrink
    always_comb
    begin
        sum_next  = sum_reg;
        fill_next = fill_reg;
        wpos_next = wpos_reg;
        if (state_reg == ST_READ)
        begin
            sum_next = sum_reg + SUM_W'(signed'(samp_reg));
            if (evict_reg)
            begin
                sum_next  = sum_next - SUM_W'(signed'(old_data));
                fill_next = eff_win;
            end
            else
                fill_next = fill_reg + 1'b1;
            if ({{(HELD_W > AW ? HELD_W - AW : 0){1'b0}}, wpos_reg} + 1'b1 >= eff_win)
                wpos_next = '0;
            else
                wpos_next = wpos_reg + 1'b1;
        end
    end

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_READ;
            ST_READ: state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_OUT;
            ST_OUT:  if (out_ch.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            win_reg    <= HELD_W'(1);
            fill_reg   <= '0;
            wpos_reg   <= '0;
            sum_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                win_reg <= cfg_wdata;
            if (accept)
            begin
                fill_reg <= fill_use;
                wpos_reg <= pos_use;
                if (in_ch.restart)
                    sum_reg <= '0;
            end
            else
            begin
                fill_reg <= fill_next;
                wpos_reg <= wpos_next;
                sum_reg  <= sum_next;
            end
            ovalid_reg <= (state_next == ST_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            samp_reg  <= in_ch.sample_value;
            evict_reg <= (fill_use >= eff_win);
        end
        if (state_reg == ST_READ)
            held_reg <= evict_reg ? eff_win : fill_reg + 1'b1;
        if (div_done)
            mean_reg <= quot;
    end

    // magnitude times 1000 as shifts and adds (1024 - 16 - 8)
    // the full magnitude is kept so the most negative sum scales correctly
    assign mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mag_scaled = (NUM_W'(mag) << 10) - (NUM_W'(mag) << 4) - (NUM_W'(mag) << 3);

    // divider starts the cycle after the sum update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_start_reg <= 1'b0;
        else
            div_start_reg <= (state_reg == ST_READ);
    end

    swm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (mag_scaled),
        .den   ({held_reg, {FRACTION_BITS{1'b0}}}),
        .neg   (sum_reg[SUM_W-1]),
        .done  (div_done),
        .quot  (quot)
    );

    assign out_ch.valid            = ovalid_reg;
    assign out_ch.mean_thousandths = mean_reg;
    assign out_ch.samples_held     = held_reg;

    // no new request while a result waits
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
    // fill count never passes the window maximum
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= HELD_W'(WINDOW_MAX)) else $error("fill count overflow");
    // an accepted request reaches the ring update next cycle
    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> state_reg == ST_READ) else $error("missed update");
endmodule

>>> tb/tb_sliding_window_mean.sv
// testbench for the moving average block: directed and random samples against a local predictor
`timescale 1ns / 1ps
module tb_sliding_window_mean;
    import swm_pkg::*;

    typedef struct packed {
        logic signed [MEAN_W-1:0] mean;
        logic [HELD_W-1:0]        held;
    } mean_result_t;

    localparam int WATCHDOG_LIMIT = 4000;
    // drain time after the last result, before a register write or the end of the test
    localparam int SETTLE_CYCLES  = 80;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [10:0] cfg_wdata;

    swm_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) in_ch ();
    swm_out_if out_ch ();

    sliding_window_mean dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // predictor state, mirrors the block's window, sum and ring
    logic [31:0]       ring_copy [WINDOW_MAX_DEF];
    bit                ring_written [WINDOW_MAX_DEF];
    logic [SUM_W-1:0]  running_sum;
    int                fill_cnt;
    int                wr_pos;
    logic [10:0]       window_reg;

    mean_result_t      expected_means [$];
    int                error_count;
    int                idle_cycles;
    // when set, neither side inserts gaps or stalls
    bit                no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // window register clamped the way the block uses it
    function automatic int clamped_window();
        if (window_reg == 0)
            return 1;
        if (window_reg > WINDOW_MAX_DEF)
            return WINDOW_MAX_DEF;
        return int'(window_reg);
    endfunction

    // true when this request would subtract a ring slot never written
    function automatic bit hits_unwritten(bit restart);
        int w;
        int pos;
        int fill;
        w = clamped_window();
        pos = restart ? 0 : wr_pos;
        fill = restart ? 0 : fill_cnt;
        if (pos >= w)
            pos = 0;
        return (fill >= w) && !ring_written[pos];
    endfunction

    // advance the predictor by one sample and return the expected mean
    function automatic mean_result_t advance_mean(logic [31:0] sample, bit restart);
        int w;
        logic [SUM_W-1:0] wide;
        logic [SUM_W-1:0] mag;
        longint unsigned q;
        longint unsigned denom;
        int held;
        bit neg;
        mean_result_t r;
        w = clamped_window();
        wide = {{(SUM_W-32){sample[31]}}, sample};
        if (restart)
        begin
            running_sum = '0;
            fill_cnt = 0;
            wr_pos = 0;
        end
        if (wr_pos >= w)
            wr_pos = 0;
        if (fill_cnt < w)
            fill_cnt++;
        else
        begin
            running_sum = running_sum - {{(SUM_W-32){ring_copy[wr_pos][31]}}, ring_copy[wr_pos]};
            fill_cnt = w;
        end
        ring_copy[wr_pos] = sample;
        ring_written[wr_pos] = 1'b1;
        running_sum = running_sum + wide;
        wr_pos = (wr_pos + 1) % w;
        held = (fill_cnt < w) ? fill_cnt : w;
        neg = running_sum[SUM_W-1];
        mag = neg ? -running_sum : running_sum;
        denom = longint'(held) << FRACTION_BITS_DEF;
        q = (longint'(mag) * SCALE) / denom;
        if (neg)
            q = -q;
        r.mean = q[MEAN_W-1:0];
        r.held = held[HELD_W-1:0];
        return r;
    endfunction

    // send one request; valid stays high when the next one follows with no gap
    task automatic send_sample(logic [31:0] sample, bit restart);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        // never let a window change pull in a slot that holds nothing
        if (hits_unwritten(restart))
            restart = 1'b1;
        in_ch.valid <= 1'b1;
        in_ch.sample_value <= sample;
        in_ch.restart <= restart;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_means.push_back(advance_mean(sample, restart));
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_means.size() != 0)
            @(posedge clk);
    endtask

    // register writes only once the block has gone quiet
    task automatic write_window(logic [10:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        window_reg = value;
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 8) - 4;
            3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    // extremes of the sample field at the reset window of one
    task automatic test_reset_window();
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0001, 1'b1);
        send_sample(32'h0001_0000, 1'b0);
        send_sample(32'hffff_0000, 1'b1);
    endtask

    // register zero acts as one, above the maximum saturates
    task automatic test_window_extremes();
        write_window(11'd0);
        send_sample(32'h0003_0000, 1'b1);
        send_sample(32'h7fff_ffff, 1'b0);
        write_window(11'd2047);
        send_sample(32'h7fff_ffff, 1'b1);
        repeat (5) send_sample(32'h7fff_ffff, 1'b0);
        repeat (4) send_sample(32'h8000_0000, 1'b0);
        write_window(11'd1024);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h1234_5678, 1'b0);
    endtask

    // window shrinks with a full ring and no restart: the sum carries over
    task automatic test_shrink_without_restart();
        write_window(11'd8);
        send_sample(32'h0010_0000, 1'b1);
        repeat (10) send_sample($urandom, 1'b0);
        write_window(11'd3);
        repeat (6) send_sample($urandom, 1'b0);
    endtask

    // sender holds off until every result is back, then resumes
    task automatic test_drain_pause();
        repeat (10) send_sample(random_sample(), 1'b0);
        drain_results();
        repeat (10) send_sample(random_sample(), 1'b0);
    endtask

    // random phases, mostly short windows so the ring wraps many times
    task automatic test_random_phases();
        int sent;
        int count;
        sent = 0;
        while (sent < 900)
        begin
            case ($urandom_range(0, 9))
                0: write_window($urandom_range(0, 2047));
                1: write_window($urandom_range(17, 64));
                default: write_window($urandom_range(1, 16));
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            count = $urandom_range(20, 60);
            for (int i = 0; i < count; i++)
                send_sample(random_sample(), (i == 0) || ($urandom_range(0, 19) == 0));
            sent += count;
        end
        no_gaps = 1'b0;
    endtask

    // result side: random stall before each result
    initial
    begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
        end
    end

    // compare each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        mean_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_means.size() == 0)
            begin
                $display("%0t: unexpected result mean=%0d held=%0d", $time,
                         out_ch.mean_thousandths, out_ch.samples_held);
                error_count++;
            end
            else
            begin
                want = expected_means.pop_front();
                if (out_ch.mean_thousandths !== want.mean)
                begin
                    $display("%0t: mean_thousandths expected %0d actual %0d", $time,
                             want.mean, out_ch.mean_thousandths);
                    error_count++;
                end
                if (out_ch.samples_held !== want.held)
                begin
                    $display("%0t: samples_held expected %0d actual %0d", $time,
                             want.held, out_ch.samples_held);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_value = '0;
        in_ch.restart = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        running_sum = '0;
        fill_cnt = 0;
        wr_pos = 0;
        window_reg = 11'd1;
        foreach (ring_written[i])
            ring_written[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_window_extremes();
        test_shrink_without_restart();
        test_drain_pause();
        test_random_phases();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
